### rtl/bdpc_pkg.sv
// ----------------------------------------------------------------------------
// Button debounce and press classifier package
// Shared widths, register indexes, reset values and event codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdpc_pkg;

	// Field widths.
	localparam int PIN_W      = 8;
	localparam int TIME_W     = 32;
	localparam int CFG_W      = 16;
	localparam int CNT_W      = 8;
	localparam int EV_W       = 2;
	localparam int CFG_IDX_W  = 3;

	// Number of buttons with an event port and a mask bit.
	localparam int REPORTED   = 4;

	// Default button count.
	localparam int NUM_BUTTONS_DEF = 4;

	// Register reset values.
	localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [CFG_W-1:0] LONG_RST     = 16'd500;
	localparam logic [CFG_W-1:0] WINDOW_RST   = 16'd300;

	// Presses counted before a double press is reported.
	localparam logic [CNT_W-1:0] DOUBLE_COUNT = 8'd2;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE_TIME   = 3'd0,
		REG_LONG_PRESS_TIME = 3'd1,
		REG_DOUBLE_WINDOW   = 3'd2,
		REG_EVENTS_ENABLED  = 3'd3,
		REG_EXPANDER        = 3'd4
	} cfg_reg_t;

	// Per-button event codes.
	typedef enum logic [EV_W-1:0] {
		EV_NONE   = 2'd0,
		EV_PRESS  = 2'd1,
		EV_DOUBLE = 2'd2,
		EV_LONG   = 2'd3
	} event_t;

endpackage

### rtl/button_debounce_press_classifier_top.sv
// ----------------------------------------------------------------------------
// Button debounce and press classifier
// Data path: input register, per-button logic, then result register.
// Throughput: one sample per cycle unless out_stall holds the result
// register; the per-button state is written as the result register loads.
// Reset: arst_n clears all button state, the pipeline valids and restores
// the register defaults. The block is ready right after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_debounce_press_classifier_top #(
	parameter int NUM_BUTTONS = bdpc_pkg::NUM_BUTTONS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write channel.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bdpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bdpc_pkg::CFG_W-1:0]    cfg_data,
	// Sample channel.
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bdpc_pkg::PIN_W-1:0]    pin_sample,
	input  logic [bdpc_pkg::TIME_W-1:0]   timestamp,
	// Result channel.
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bdpc_pkg::EV_W-1:0]     event_button0,
	output logic [bdpc_pkg::EV_W-1:0]     event_button1,
	output logic [bdpc_pkg::EV_W-1:0]     event_button2,
	output logic [bdpc_pkg::EV_W-1:0]     event_button3,
	output logic [bdpc_pkg::REPORTED-1:0] debounced_mask,
	output logic [bdpc_pkg::REPORTED-1:0] long_hold_mask
);

	localparam int TW = bdpc_pkg::TIME_W;
	localparam int CW = bdpc_pkg::CNT_W;
	localparam int RP = bdpc_pkg::REPORTED;

	// Configuration registers.
	logic [bdpc_pkg::CFG_W-1:0] debounce_q;
	logic [bdpc_pkg::CFG_W-1:0] long_q;
	logic [bdpc_pkg::CFG_W-1:0] window_q;
	logic                       events_en_q;
	logic                       present_q;

	// Input stage.
	logic                       valid_s1;
	logic [bdpc_pkg::PIN_W-1:0] pins_s1;
	logic [TW-1:0]              ts_s1;

	// Result register.
	logic                       out_valid_q;
	logic [bdpc_pkg::EV_W-1:0]  ev_q [RP];
	logic [RP-1:0]              deb_mask_q;
	logic [RP-1:0]              lng_mask_q;

	// Per-button state.
	logic          raw_q    [NUM_BUTTONS];
	logic          stable_q [NUM_BUTTONS];
	logic [TW-1:0] lct_q    [NUM_BUTTONS];
	logic [TW-1:0] press_q  [NUM_BUTTONS];
	logic [TW-1:0] rel_q    [NUM_BUTTONS];
	logic [CW-1:0] cnt_q    [NUM_BUTTONS];

	// Next state and per-button results.
	logic          raw_n    [NUM_BUTTONS];
	logic          stable_n [NUM_BUTTONS];
	logic [TW-1:0] lct_n    [NUM_BUTTONS];
	logic [TW-1:0] press_n  [NUM_BUTTONS];
	logic [TW-1:0] rel_n    [NUM_BUTTONS];
	logic [CW-1:0] cnt_n    [NUM_BUTTONS];
	logic [bdpc_pkg::EV_W-1:0] ev_c [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0]    deb_c;
	logic [NUM_BUTTONS-1:0]    lng_c;

	// Reported view, zero for missing buttons.
	logic [bdpc_pkg::EV_W-1:0] ev_rep [RP];
	logic [RP-1:0]             deb_rep;
	logic [RP-1:0]             lng_rep;

	logic accept;
	logic fire;
	logic update;

	// Handshake: the input stage moves on when the result register is free.
	assign fire      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !fire;
	assign accept    = in_valid && !in_stall;
	assign update    = fire && present_q;
	assign cfg_ready = 1'b1;

	// Configuration writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= bdpc_pkg::DEBOUNCE_RST;
			long_q      <= bdpc_pkg::LONG_RST;
			window_q    <= bdpc_pkg::WINDOW_RST;
			events_en_q <= 1'b0;
			present_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bdpc_pkg::REG_DEBOUNCE_TIME:   debounce_q  <= cfg_data;
				bdpc_pkg::REG_LONG_PRESS_TIME: long_q      <= cfg_data;
				bdpc_pkg::REG_DOUBLE_WINDOW:   window_q    <= cfg_data;
				bdpc_pkg::REG_EVENTS_ENABLED:  events_en_q <= cfg_data[0];
				bdpc_pkg::REG_EXPANDER:        present_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pins_s1 <= pin_sample;
			ts_s1   <= timestamp;
		end
	end

	// Per-button debounce and classification.
	for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
		always_comb begin
			logic          held;
			logic [TW-1:0] since_change;
			logic [TW-1:0] since_rel;
			logic [TW-1:0] since_press;
			held         = !pins_s1[b];
			raw_n[b]     = held;
			lct_n[b]     = (held != raw_q[b]) ? ts_s1 : lct_q[b];
			stable_n[b]  = stable_q[b];
			press_n[b]   = press_q[b];
			rel_n[b]     = rel_q[b];
			cnt_n[b]     = cnt_q[b];
			ev_c[b]      = bdpc_pkg::EV_NONE;
			since_change = ts_s1 - lct_n[b];
			since_rel    = ts_s1 - rel_q[b];
			since_press  = ts_s1 - press_q[b];
			if (since_change > {{(TW-bdpc_pkg::CFG_W){1'b0}}, debounce_q}
					&& held != stable_q[b]) begin
				stable_n[b] = held;
				if (held) begin
					// Debounced press: count toward a double press.
					press_n[b] = ts_s1;
					if (since_rel < {{(TW-bdpc_pkg::CFG_W){1'b0}}, window_q})
						cnt_n[b] = cnt_q[b] + CW'(1);
					else
						cnt_n[b] = CW'(1);
					if (events_en_q) begin
						ev_c[b] = bdpc_pkg::EV_PRESS;
						if (cnt_n[b] >= bdpc_pkg::DOUBLE_COUNT) begin
							ev_c[b]  = bdpc_pkg::EV_DOUBLE;
							cnt_n[b] = '0;
						end
					end
				end else begin
					// Debounced release: long press if held long enough.
					rel_n[b] = ts_s1;
					if (since_press > {{(TW-bdpc_pkg::CFG_W){1'b0}}, long_q}
							&& events_en_q)
						ev_c[b] = bdpc_pkg::EV_LONG;
				end
			end
		end

		// Masks use the state after this sample.
		always_comb begin
			logic [TW-1:0] held_for;
			held_for  = ts_s1 - press_n[b];
			deb_c[b]  = stable_n[b];
			lng_c[b]  = stable_n[b]
				&& (held_for > {{(TW-bdpc_pkg::CFG_W){1'b0}}, long_q});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				raw_q[b]    <= 1'b0;
				stable_q[b] <= 1'b0;
				lct_q[b]    <= '0;
				press_q[b]  <= '0;
				rel_q[b]    <= '0;
				cnt_q[b]    <= '0;
			end else if (update) begin
				raw_q[b]    <= raw_n[b];
				stable_q[b] <= stable_n[b];
				lct_q[b]    <= lct_n[b];
				press_q[b]  <= press_n[b];
				rel_q[b]    <= rel_n[b];
				cnt_q[b]    <= cnt_n[b];
			end
		end
	end

	// Map tracked buttons onto the reported slots.
	for (genvar r = 0; r < RP; r++) begin : g_rep
		if (r < NUM_BUTTONS) begin : g_on
			assign ev_rep[r]  = present_q ? ev_c[r] : bdpc_pkg::EV_NONE;
			assign deb_rep[r] = present_q && deb_c[r];
			assign lng_rep[r] = present_q && lng_c[r];
		end else begin : g_off
			assign ev_rep[r]  = bdpc_pkg::EV_NONE;
			assign deb_rep[r] = 1'b0;
			assign lng_rep[r] = 1'b0;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			for (int r = 0; r < RP; r++) begin
				ev_q[r] <= ev_rep[r];
			end
			deb_mask_q <= deb_rep;
			lng_mask_q <= lng_rep;
		end
	end

	assign out_valid      = out_valid_q;
	assign event_button0  = ev_q[0];
	assign event_button1  = ev_q[1];
	assign event_button2  = ev_q[2];
	assign event_button3  = ev_q[3];
	assign debounced_mask = deb_mask_q;
	assign long_hold_mask = lng_mask_q;

	// A long hold is only reported for a button that is debounced pressed.
	a_long_in_deb: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((long_hold_mask & ~debounced_mask) == '0))
		else $error("long hold reported for a released button");

	// A press or double press leaves button 0 debounced pressed.
	a_press_deb: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_button0 == bdpc_pkg::EV_PRESS
			|| event_button0 == bdpc_pkg::EV_DOUBLE) |-> debounced_mask[0])
		else $error("press event without debounced press");

	// A long press event is a release.
	a_long_rel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_button0 == bdpc_pkg::EV_LONG |-> !debounced_mask[0])
		else $error("long press event while still pressed");

	// Button state moves only when a sample leaves the input stage.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!update |=> $stable(stable_q[0]) && $stable(cnt_q[0]))
		else $error("button state changed without a sample");

	// A double press clears the press counter.
	a_double_clr: assert property (@(posedge clk) disable iff (!arst_n)
		update && ev_c[0] == bdpc_pkg::EV_DOUBLE |=> cnt_q[0] == '0)
		else $error("press counter not cleared after double press");

endmodule
